// File: hw/rtl/frnp_pkg.sv
// Shared constants, codes and types of the read-name parser.
package frnp_pkg;

    localparam int MAX_NAME_LEN = 255;
    localparam int POS_W        = $clog2(MAX_NAME_LEN + 1);
    localparam int FIFO_DEPTH   = 2;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] TOK1_COLONS = 4'd6;
    localparam logic [3:0] TOK2_COLONS = 4'd3;

    localparam logic [1:0] SCHEME_GENERIC = 2'd0;
    localparam logic [1:0] SCHEME_SINGLE  = 2'd1;
    localparam logic [1:0] SCHEME_PAIRED  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_COLONS   = 2'd1;
    localparam logic [1:0] STATUS_FRAGMENT = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

    // Per-name summary passed from the scanner to the result stage
    typedef struct packed {
        logic             overflow;
        logic             lead_only;
        logic [POS_W-1:0] char_count;
        logic [POS_W-1:0] tok_start;
        logic [POS_W-1:0] tok_end;
        logic             colons_ok;
        logic             frag_ok;
        logic             frag_one;
        logic             suffix_pair;
        logic             suffix_second;
    } name_sum_t;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// File: hw/rtl/frnp_scan.sv
// Front end: per-character scan of one read name into a summary request.
module frnp_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          name_char,
    input  logic                is_last_char,
    output logic                push,
    output frnp_pkg::name_sum_t sum
);
    import frnp_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD, PH_TOK1, PH_GAP, PH_TOK2, PH_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        FR_AWAIT, FR_DIGITS, FR_OK, FR_BAD
    } frag_t;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_NAME_LEN);

    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic [3:0]       col1_reg, col1_next;
    logic [3:0]       col2_reg, col2_next;
    logic [15:0]      prev_reg, prev_next;
    logic [1:0]       fval_reg, fval_next;
    frag_t            fprog_reg, fprog_next;
    logic             ovf_reg, ovf_next;

    logic             ws;
    logic             dig;
    logic             do_t1;
    logic             do_t2;
    logic [1:0]       dclamp;
    logic [POS_W-1:0] tok_len;

    assign ws     = is_ws(name_char);
    assign dig    = is_digit(name_char);
    assign dclamp = (name_char[3:0] > 4'd2) ? 2'd3 : name_char[1:0];

    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        start_next = start_reg;
        end_next   = end_reg;
        col1_next  = col1_reg;
        col2_next  = col2_reg;
        prev_next  = prev_reg;
        fval_next  = fval_reg;
        fprog_next = fprog_reg;
        ovf_next   = ovf_reg;
        do_t1      = 1'b0;
        do_t2      = 1'b0;

        if (ovf_reg || (pos_reg >= MAX_POS))
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (!ws)
                    begin
                        start_next = pos_reg;
                        phase_next = PH_TOK1;
                        do_t1      = 1'b1;
                    end
                end
                PH_TOK1:
                begin
                    if (ws)
                        phase_next = PH_GAP;
                    else
                        do_t1 = 1'b1;
                end
                PH_GAP:
                begin
                    if (!ws)
                    begin
                        phase_next = PH_TOK2;
                        do_t2      = 1'b1;
                    end
                end
                PH_TOK2:
                begin
                    if (ws)
                        phase_next = PH_TAIL;
                    else
                        do_t2 = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (do_t1)
            begin
                if ((name_char == CH_COLON) && (col1_reg != 4'hF))
                    col1_next = col1_reg + 1'b1;
                prev_next = {prev_reg[7:0], name_char};
                end_next  = pos_reg + 1'b1;
            end

            if (do_t2)
            begin
                if ((name_char == CH_COLON) && (col2_reg != 4'hF))
                    col2_next = col2_reg + 1'b1;
                unique case (fprog_reg)
                    FR_AWAIT:
                    begin
                        if (dig)
                        begin
                            fval_next  = dclamp;
                            fprog_next = FR_DIGITS;
                        end
                        else
                        begin
                            fprog_next = FR_BAD;
                        end
                    end
                    FR_DIGITS:
                    begin
                        // A further digit after a nonzero value always exceeds two
                        if (dig)
                            fval_next = (fval_reg == 2'd0) ? dclamp : 2'd3;
                        else if ((name_char == CH_COLON) && (fval_reg == 2'd1 || fval_reg == 2'd2))
                            fprog_next = FR_OK;
                        else
                            fprog_next = FR_BAD;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign tok_len = end_next - start_next;
    assign push    = take && is_last_char;

    always_comb
    begin
        sum.overflow      = ovf_next;
        sum.lead_only     = (phase_next == PH_LEAD);
        sum.char_count    = pos_next;
        sum.tok_start     = start_next;
        sum.tok_end       = end_next;
        sum.colons_ok     = (col1_next == TOK1_COLONS) && (col2_next == TOK2_COLONS);
        sum.frag_ok       = (fprog_next == FR_OK);
        sum.frag_one      = (fval_next == 2'd1);
        sum.suffix_pair   = (tok_len >= POS_W'(2)) && (prev_next[15:8] == CH_SLASH)
                            && ((prev_next[7:0] == CH_ONE) || (prev_next[7:0] == CH_TWO));
        sum.suffix_second = (prev_next[7:0] == CH_TWO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_LEAD;
            start_reg <= '0;
            end_reg   <= '0;
            col1_reg  <= '0;
            col2_reg  <= '0;
            prev_reg  <= '0;
            fval_reg  <= '0;
            fprog_reg <= FR_AWAIT;
            ovf_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (is_last_char)
            begin
                // Drop per-name state once the summary is queued
                pos_reg   <= '0;
                phase_reg <= PH_LEAD;
                start_reg <= '0;
                end_reg   <= '0;
                col1_reg  <= '0;
                col2_reg  <= '0;
                prev_reg  <= '0;
                fval_reg  <= '0;
                fprog_reg <= FR_AWAIT;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                start_reg <= start_next;
                end_reg   <= end_next;
                col1_reg  <= col1_next;
                col2_reg  <= col2_next;
                prev_reg  <= prev_next;
                fval_reg  <= fval_next;
                fprog_reg <= fprog_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_LEAD) |-> (end_reg > start_reg))
        else $error("token end not beyond token start");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!ovf_reg) |-> (pos_reg <= MAX_POS))
        else $error("position ran past the name limit without overflow");

endmodule

// File: hw/rtl/frnp_queue.sv
// Short queue of name summaries between the scanner and the result stage.
module frnp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  frnp_pkg::name_sum_t wdata,
    input  logic                pop,
    output frnp_pkg::name_sum_t rdata,
    output logic                full,
    output logic                empty
);
    import frnp_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);

    name_sum_t        mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == DEPTH_CNT);
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("pop from empty queue");

endmodule

// File: hw/rtl/frnp_finish.sv
// Back end: turns a name summary into the result and holds it for the receiver.
module frnp_finish (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          scheme,
    input  logic                sum_valid,
    input  frnp_pkg::name_sum_t sum,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          base_start,
    output logic [7:0]          base_length,
    output logic                paired_flag,
    output logic                first_mate_flag,
    output logic [1:0]          parse_status
);
    import frnp_pkg::*;

    logic             out_valid_reg;
    logic [7:0]       start_reg;
    logic [7:0]       len_reg;
    logic             paired_reg;
    logic             first_reg;
    logic [1:0]       status_reg;

    logic [POS_W-1:0] start_c;
    logic [POS_W-1:0] len_c;
    logic [POS_W-1:0] tok_len;
    logic             paired_c;
    logic             first_c;
    logic [1:0]       status_c;

    assign pop     = sum_valid && (!out_valid_reg || out_ready);
    assign tok_len = sum.tok_end - sum.tok_start;

    always_comb
    begin
        start_c  = '0;
        len_c    = '0;
        paired_c = 1'b0;
        first_c  = 1'b1;
        status_c = STATUS_OK;
        priority if (sum.overflow)
        begin
            status_c = STATUS_TOO_LONG;
        end
        else if ((scheme == SCHEME_SINGLE) || (scheme == SCHEME_PAIRED))
        begin
            if (!sum.colons_ok)
                status_c = STATUS_COLONS;
            else if ((scheme == SCHEME_PAIRED) && !sum.frag_ok)
                status_c = STATUS_FRAGMENT;
            else
            begin
                start_c = sum.tok_start;
                len_c   = tok_len;
                if (scheme == SCHEME_PAIRED)
                begin
                    paired_c = 1'b1;
                    first_c  = sum.frag_one;
                end
            end
        end
        else if (sum.lead_only)
        begin
            len_c = sum.char_count;
        end
        else
        begin
            start_c = sum.tok_start;
            len_c   = tok_len;
            if (sum.suffix_pair)
            begin
                // Strip the mate suffix
                paired_c = 1'b1;
                first_c  = !sum.suffix_second;
                len_c    = tok_len - POS_W'(2);
            end
        end

        if (status_c != STATUS_OK)
        begin
            start_c  = '0;
            len_c    = '0;
            paired_c = 1'b0;
            first_c  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            start_reg  <= 8'(start_c);
            len_reg    <= 8'(len_c);
            paired_reg <= paired_c;
            first_reg  <= first_c;
            status_reg <= status_c;
        end
    end

    assign out_valid       = out_valid_reg;
    assign base_start      = start_reg;
    assign base_length     = len_reg;
    assign paired_flag     = paired_reg;
    assign first_mate_flag = first_reg;
    assign parse_status    = status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_OK)) |->
        (start_reg == 8'd0 && len_reg == 8'd0 && !paired_reg && !first_reg))
        else $error("failed name carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("stalled result lost");

endmodule

// File: hw/rtl/fastq_read_name_parser_top.sv
// Top level of the read-name parser: config register, scanner, queue, result stage.
//
// Usage:
//   Input channel (in_valid/in_ready): one byte of a read name per request,
//   name_char, with is_last_char high on the final byte of the name.
//   Output channel (out_valid/out_ready): one result per name, base_start,
//   base_length, paired_flag, first_mate_flag and parse_status.
//   cfg_we/cfg_wdata write name_scheme; write it only while no name is in flight.
// Throughput: one byte per cycle while in_ready is high, set by the scanner's per-byte update.
// Path: the summary of the last accepted byte is written into the queue, and moves
//   into the output register once that register is free or being emptied.
// Reset: name_scheme returns to the generic scheme and all per-name state
//   clears; no result is pending.
// Stall: while out_ready is low the result holds; the two-entry queue keeps
//   taking names, and in_ready falls only when the queue is full.
module fastq_read_name_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] name_char,
    input  logic       is_last_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] base_start,
    output logic [7:0] base_length,
    output logic       paired_flag,
    output logic       first_mate_flag,
    output logic [1:0] parse_status
);
    import frnp_pkg::*;

    logic       scheme_reg;
    logic [1:0] scheme_q_reg;
    logic       take;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    name_sum_t  sum_in;
    name_sum_t  sum_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_q_reg <= SCHEME_GENERIC;
            scheme_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            scheme_q_reg <= cfg_wdata;
            scheme_reg   <= 1'b1;
        end
    end

    assign in_ready = !full;
    assign take     = in_valid && in_ready;

    frnp_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .name_char    (name_char),
        .is_last_char (is_last_char),
        .push         (push),
        .sum          (sum_in)
    );

    frnp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (sum_in),
        .pop   (pop),
        .rdata (sum_out),
        .full  (full),
        .empty (empty)
    );

    frnp_finish u_finish (
        .clk             (clk),
        .rst_n           (rst_n),
        .scheme          (scheme_q_reg),
        .sum_valid       (!empty),
        .sum             (sum_out),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .base_start      (base_start),
        .base_length     (base_length),
        .paired_flag     (paired_flag),
        .first_mate_flag (first_mate_flag),
        .parse_status    (parse_status)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (!scheme_reg) |-> (scheme_q_reg == SCHEME_GENERIC))
        else $error("scheme changed without a write");

endmodule

// File: tb/sv/tb.sv
// Testbench for the read-name parser: directed and random names checked against a local parser.
`timescale 1ns / 1ps

module tb;
    import frnp_pkg::*;

    localparam logic [1:0] SCHEME_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [7:0] char_q_t [$];

    typedef struct packed {
        logic [7:0] start;
        logic [7:0] length;
        logic       paired;
        logic       first;
        logic [1:0] status;
    } name_result_t;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_TOKEN1,
        SCAN_GAP,
        SCAN_TOKEN2,
        SCAN_TAIL
    } scan_phase_t;

    typedef enum logic [1:0] {
        FRAG_WAIT,
        FRAG_DIGITS,
        FRAG_GOOD,
        FRAG_BAD
    } frag_state_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] name_char;
    logic       is_last_char;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] base_start;
    logic [7:0] base_length;
    logic       paired_flag;
    logic       first_mate_flag;
    logic [1:0] parse_status;

    // Local parser state
    logic [1:0]  scheme_m;
    int unsigned char_pos;
    scan_phase_t phase_m;
    int unsigned tok_start_m;
    int unsigned tok_end_m;
    logic [3:0]  colons1_m;
    logic [3:0]  colons2_m;
    logic [7:0]  last_c;
    logic [7:0]  prev_c;
    logic [1:0]  frag_val_m;
    frag_state_t frag_m;
    logic        overflow_m;

    name_result_t name_results_due [$];
    int mismatches = 0;
    int names_seen = 0;
    int cycles = 0;
    int burst_left = 0;
    int ready_left = 0;

    fastq_read_name_parser_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .name_char      (name_char),
        .is_last_char   (is_last_char),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .base_start     (base_start),
        .base_length    (base_length),
        .paired_flag    (paired_flag),
        .first_mate_flag(first_mate_flag),
        .parse_status   (parse_status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic decimal(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic void clear_name();
        char_pos    = 0;
        phase_m     = SCAN_LEAD;
        tok_start_m = 0;
        tok_end_m   = 0;
        colons1_m   = '0;
        colons2_m   = '0;
        last_c      = '0;
        prev_c      = '0;
        frag_val_m  = '0;
        frag_m      = FRAG_WAIT;
        overflow_m  = 1'b0;
    endfunction

    function automatic void take_token1(input logic [7:0] c, input int unsigned at);
        if (c == CH_COLON && colons1_m != 4'hF)
            colons1_m++;
        prev_c    = last_c;
        last_c    = c;
        tok_end_m = at + 1;
    endfunction

    function automatic void take_token2(input logic [7:0] c);
        int digit;
        int v;
        digit = int'(c) - int'(CH_ZERO);
        if (c == CH_COLON && colons2_m != 4'hF)
            colons2_m++;
        case (frag_m)
            FRAG_WAIT:
                if (decimal(c))
                begin
                    frag_val_m = (digit > 2) ? 2'd3 : 2'(digit);
                    frag_m     = FRAG_DIGITS;
                end
                else
                    frag_m = FRAG_BAD;
            FRAG_DIGITS:
                if (decimal(c))
                begin
                    // saturate anything above two
                    if (frag_val_m != 2'd3)
                    begin
                        v = int'(frag_val_m) * 10 + digit;
                        frag_val_m = (v > 2) ? 2'd3 : 2'(v);
                    end
                end
                else if (c == CH_COLON && frag_val_m != 2'd0 && frag_val_m != 2'd3)
                    frag_m = FRAG_GOOD;
                else
                    frag_m = FRAG_BAD;
            default: ;
        endcase
    endfunction

    // Advance the local parser by one accepted character
    function automatic void parse_name_char(input logic [7:0] c, input logic last);
        name_result_t r;
        int unsigned  at;
        int unsigned  span;
        if (overflow_m || char_pos >= MAX_NAME_LEN)
            overflow_m = 1'b1;
        else
        begin
            at = char_pos;
            char_pos = at + 1;
            case (phase_m)
                SCAN_LEAD:
                    if (!blank(c))
                    begin
                        tok_start_m = at;
                        phase_m     = SCAN_TOKEN1;
                        take_token1(c, at);
                    end
                SCAN_TOKEN1:
                    if (blank(c))
                        phase_m = SCAN_GAP;
                    else
                        take_token1(c, at);
                SCAN_GAP:
                    if (!blank(c))
                    begin
                        phase_m = SCAN_TOKEN2;
                        take_token2(c);
                    end
                SCAN_TOKEN2:
                    if (blank(c))
                        phase_m = SCAN_TAIL;
                    else
                        take_token2(c);
                default: ;
            endcase
        end
        if (last)
        begin
            r        = '0;
            r.first  = 1'b1;
            r.status = STATUS_OK;
            span     = tok_end_m - tok_start_m;
            if (overflow_m)
                r.status = STATUS_TOO_LONG;
            else if (scheme_m == SCHEME_SINGLE || scheme_m == SCHEME_PAIRED)
            begin
                if (colons1_m != TOK1_COLONS || colons2_m != TOK2_COLONS)
                    r.status = STATUS_COLONS;
                else if (scheme_m == SCHEME_PAIRED && frag_m != FRAG_GOOD)
                    r.status = STATUS_FRAGMENT;
                else
                begin
                    r.start  = 8'(tok_start_m);
                    r.length = 8'(span);
                    if (scheme_m == SCHEME_PAIRED)
                    begin
                        r.paired = 1'b1;
                        r.first  = (frag_val_m == 2'd1);
                    end
                end
            end
            else if (phase_m == SCAN_LEAD)
                r.length = 8'(char_pos);
            else
            begin
                r.start  = 8'(tok_start_m);
                r.length = 8'(span);
                if (span >= 2 && prev_c == CH_SLASH && (last_c == CH_ONE || last_c == CH_TWO))
                begin
                    r.paired = 1'b1;
                    r.first  = (last_c != CH_TWO);
                    r.length = 8'(span - 2);
                end
            end
            if (r.status != STATUS_OK)
            begin
                r.start  = '0;
                r.length = '0;
                r.paired = 1'b0;
                r.first  = 1'b0;
            end
            name_results_due = {name_results_due, r};
            clear_name();
        end
    endfunction

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $time, what);
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
            flag_mismatch($sformatf("name %0d %s expected %0d got %0d",
                                    names_seen, field, want, got));
    endfunction

    always @(posedge clk)
    begin : result_check
        name_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (name_results_due.size() == 0)
                flag_mismatch($sformatf("result with nothing due: start %0d length %0d status %0d",
                                        base_start, base_length, parse_status));
            else
            begin
                want = name_results_due.pop_front();
                check_field("base_start", want.start, base_start);
                check_field("base_length", want.length, base_length);
                check_field("paired_flag", 8'(want.paired), 8'(paired_flag));
                check_field("first_mate_flag", 8'(want.first), 8'(first_mate_flag));
                check_field("parse_status", 8'(want.status), 8'(parse_status));
            end
            names_seen++;
        end
    end

    // Result side stalls in runs; long ready stretches now and then
    always @(posedge clk)
    begin
        if (ready_left > 0)
            ready_left--;
        else if (out_ready)
        begin
            out_ready <= 1'b0;
            if ($urandom_range(0, 19) == 0)
                ready_left = $urandom_range(20, 40);
            else if ($urandom_range(0, 3) == 0)
                ready_left = $urandom_range(4, 10);
            else
                ready_left = $urandom_range(0, 2);
        end
        else
        begin
            out_ready <= 1'b1;
            ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 20);
        end
    end

    // Send one character request; bursts of requests with idle gaps in between
    task automatic send_char(input logic [7:0] c, input logic last);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 20)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 16);
        end
        in_valid     <= 1'b1;
        name_char    <= c;
        is_last_char <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        parse_name_char(c, last);
    endtask

    task automatic send_name(input char_q_t chars);
        for (int i = 0; i < chars.size(); i++)
            send_char(chars[i], i == chars.size() - 1);
    endtask

    // Drain, let the block settle, then write the scheme register
    task automatic set_scheme(input logic [1:0] s);
        in_valid <= 1'b0;
        while (name_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we    <= 1'b0;
        scheme_m = s;
    endtask

    function automatic char_q_t text(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q = {q, s[i]};
        return q;
    endfunction

    function automatic char_q_t filled(input logic [7:0] c, input int n);
        char_q_t q;
        repeat (n) q = {q, c};
        return q;
    endfunction

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'(8'h09 + r);
    endfunction

    function automatic logic [7:0] field_byte();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (blank(c) || c == CH_COLON);
        return c;
    endfunction

    function automatic void add_word(ref char_q_t q, input int n);
        repeat (n) q = {q, field_byte()};
    endfunction

    function automatic void add_blanks(ref char_q_t q, input int n);
        repeat (n) q = {q, blank_byte()};
    endfunction

    function automatic char_q_t random_name(input logic [1:0] s);
        char_q_t q;
        int roll;
        int colons;
        logic two_token;
        roll = $urandom_range(0, 99);
        two_token = (s == SCHEME_SINGLE || s == SCHEME_PAIRED) ? (roll < 90) : (roll < 30);
        if (roll < 3)
        begin
            // straddle the length limit
            repeat ($urandom_range(MAX_NAME_LEN - 4, MAX_NAME_LEN + 8))
                q = {q, ($urandom_range(0, 3) == 0) ? 8'($urandom) : field_byte()};
        end
        else if (roll < 12)
            repeat ($urandom_range(1, 12)) q = {q, 8'($urandom)};
        else if (two_token)
        begin
            if ($urandom_range(0, 9) == 0)
                add_blanks(q, $urandom_range(1, 2));
            colons = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : 6;
            add_word(q, $urandom_range(0, 3));
            repeat (colons)
            begin
                q = {q, CH_COLON};
                add_word(q, $urandom_range(0, 3));
            end
            add_blanks(q, $urandom_range(1, 2));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: q = {q, CH_ONE};
                4, 5, 6:    q = {q, CH_TWO};
                7:
                begin
                    q = {q, CH_ZERO};
                    q = {q, $urandom_range(0, 1) ? CH_ONE : CH_TWO};
                end
                8:
                begin
                    q = {q, 8'($urandom_range(CH_ZERO, CH_NINE))};
                    if ($urandom_range(0, 1) == 0)
                        q = {q, 8'($urandom_range(CH_ZERO, CH_NINE))};
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        q = {q, CH_ONE};
                    q = {q, field_byte()};
                end
            endcase
            colons = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 3;
            repeat (colons)
            begin
                q = {q, CH_COLON};
                add_word(q, $urandom_range(0, 3));
            end
            if ($urandom_range(0, 3) == 0)
            begin
                add_blanks(q, 1);
                add_word(q, $urandom_range(0, 4));
            end
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                add_blanks(q, $urandom_range(1, 3));
            add_word(q, $urandom_range(0, 10));
            case ($urandom_range(0, 7))
                0, 1, 2:
                begin
                    q = {q, CH_SLASH};
                    q = {q, CH_ONE};
                end
                3, 4:
                begin
                    q = {q, CH_SLASH};
                    q = {q, CH_TWO};
                end
                5:
                begin
                    q = {q, CH_SLASH};
                    q = {q, field_byte()};
                end
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                add_blanks(q, $urandom_range(1, 2));
                add_word(q, $urandom_range(0, 6));
                if ($urandom_range(0, 1) == 0)
                begin
                    q = {q, CH_SLASH};
                    q = {q, CH_TWO};
                end
            end
            if (q.size() == 0)
                q = {q, field_byte()};
        end
        return q;
    endfunction

    // Generic scheme straight out of reset
    task automatic test_generic_names();
        char_q_t q;
        send_name(text("read7/1"));
        send_name(text("read7/2"));
        send_name(text("x/3"));
        send_name(text("/2"));
        send_name(text("  ab:c/1 extra/2"));
        q = '{8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0B, 8'h0C};
        send_name(q);
        q = '{8'h00, 8'hFF, 8'h08, 8'h0E, CH_SLASH, CH_TWO};
        send_name(q);
    endtask

    task automatic test_length_limits();
        char_q_t q;
        set_scheme(SCHEME_GENERIC);
        q = filled(8'h20, MAX_NAME_LEN - 1);
        q = {q, 8'("z")};
        send_name(q);
        send_name(filled("q", MAX_NAME_LEN));
        set_scheme(SCHEME_PAIRED);
        send_name(filled(CH_COLON, MAX_NAME_LEN + 1));
    endtask

    task automatic test_single_end_names();
        set_scheme(SCHEME_SINGLE);
        send_name(text("M:1:F:7:1:11:22 1:N:0:ACGT"));
        send_name(text("a:b:c:d:e:f 1:N:0:X"));
        send_name(text("a:b:c:d:e:f:g"));
        send_name(text(":::::::::::::::::::: :::"));
    endtask

    task automatic test_paired_end_names();
        set_scheme(SCHEME_PAIRED);
        send_name(text("\ta:b:c:d:e:f:g 2:N:0:AC"));
        send_name(text("a:b:c:d:e:f:g 001:Y:0:x"));
        send_name(text("a:b:c:d:e:f:g 3:N:0:"));
        send_name(text("a:b:c:d:e:f:g :1:N:0"));
        send_name(text("a:b:c:d:e:f:g 1x:N:0:"));
        send_name(text("a:b:c:d:e:f:g 0:N:0:"));
        send_name(text("a:b:c:d:e:f:g 12:N:0:"));
        send_name(text("a:b:c:d:e:f:g 1:N:0:A trailing"));
        send_name(text("a:b 9"));
    endtask

    task automatic test_unused_scheme();
        set_scheme(SCHEME_UNUSED);
        send_name(text("ab/2"));
        send_name(text("a:b:c:d:e:f:g 1:N:0:A"));
    endtask

    task automatic test_random_names();
        logic [1:0] order [7];
        char_q_t q;
        int sent;
        order = '{SCHEME_SINGLE, SCHEME_PAIRED, SCHEME_GENERIC, SCHEME_UNUSED,
                  SCHEME_PAIRED, SCHEME_SINGLE, SCHEME_GENERIC};
        foreach (order[k])
        begin
            set_scheme(order[k]);
            sent = 0;
            while (sent < 30)
            begin
                q = random_name(order[k]);
                send_name(q);
                sent += q.size();
            end
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= SCHEME_GENERIC;
        in_valid     <= 1'b0;
        name_char    <= '0;
        is_last_char <= 1'b0;
        out_ready    <= 1'b0;
        scheme_m = SCHEME_GENERIC;
        clear_name();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_generic_names();
        test_length_limits();
        test_single_end_names();
        test_paired_end_names();
        test_unused_scheme();
        test_random_names();

        in_valid <= 1'b0;
        while (name_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (name_results_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", name_results_due.size()));
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
